FILE: rtl/core/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared types and constants of the periodic neighbour cell generator.
// ----------------------------------------------------------------------------
package pnc_pkg;

   localparam int INDEX_W     = 18;  // linear cell index width
   localparam int CODE_W      = 5;   // neighbour number width
   localparam int CFG_W       = 7;   // width of one axis size register
   localparam int CSR_INDEX_W = 2;   // configuration register index width
   localparam int STEP_W      = 3;   // front step counter width

   localparam int NUM_NEIGHBOURS = 27;
   localparam logic [CODE_W-1:0] CODE_LAST = CODE_W'(NUM_NEIGHBOURS - 1);

   // Divider retires this many quotient bits per cycle.
   localparam int DIV_BITS  = 3;
   localparam int DIV_STEPS = INDEX_W / DIV_BITS;
   // One plane size product, three row terms and three layer terms.
   localparam int MUL_STEPS = 7;

   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_Z = 2'd2;

   // Axis being divided out.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Per-axis step codes: minus one, stay, plus one.
   localparam logic [1:0] STEP_MINUS = 2'd0;
   localparam logic [1:0] STEP_STAY  = 2'd1;
   localparam logic [1:0] STEP_PLUS  = 2'd2;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_MUL,
      FR_PUSH
   } front_state_type;

   // One classified cell: the three wrapped x values and the row and layer
   // terms for the three y and z steps, all reduced modulo 2^INDEX_W.
   typedef struct packed {
      logic [2:0][INDEX_W-1:0] col;
      logic [2:0][INDEX_W-1:0] row;
      logic [2:0][INDEX_W-1:0] layer;
   } work_type;

endpackage

FILE: rtl/core/periodic_neighbour_cell_gen.sv
// ----------------------------------------------------------------------------
// periodic_neighbour_cell_gen
// Periodic 27-neighbour generator for a 3-D cell-list grid.
// ----------------------------------------------------------------------------
// An accepted cell word passes the start step, the divider, the multiplier,
//   the queue push, the back end take and the output register before its
//   first neighbour word appears.
// The back end delivers one neighbour word per cycle while the receiver is
//   ready; the front overlaps the next cell.
// Reset: synchronous; clears all handshake state and sets every axis size
//   register to 8. There is no clearing pass.
// ----------------------------------------------------------------------------
module periodic_neighbour_cell_gen
   import pnc_pkg::*;
#(
   parameter int MAX_CELLS_PER_SIDE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // Cell words in.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [INDEX_W-1:0]     req_cell_index,
   // Neighbour words out.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [INDEX_W-1:0]     rsp_neighbour_index,
   output logic [CODE_W-1:0]      rsp_offset_code,
   output logic                   rsp_forward,
   output logic                   rsp_last,
   // Axis size register writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   // Coordinates and sizes never exceed MAX_CELLS_PER_SIDE.
   localparam int AXIS_W = $clog2(MAX_CELLS_PER_SIDE + 1);

   logic [CFG_W-1:0]  cells_x_ff, cells_y_ff, cells_z_ff;
   logic [AXIS_W-1:0] nx, ny, nz;

   logic     push_valid, push_ready;
   work_type push_data;
   logic     pop_valid, pop_ready;
   work_type pop_data;

   // A size of zero counts as one cell, and sizes above the maximum are
   // held at the maximum, so every axis has a usable period.
   function automatic logic [AXIS_W-1:0] axis_size(input logic [CFG_W-1:0] v);
      logic [AXIS_W-1:0] res;
      if (v == '0) begin
         res = AXIS_W'(1);
      end else if (int'(v) > MAX_CELLS_PER_SIDE) begin
         res = AXIS_W'(MAX_CELLS_PER_SIDE);
      end else begin
         res = AXIS_W'(v);
      end
      return res;
   endfunction

   // Register writes are always taken; an index past the last register is
   // dropped without effect.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CFG_W'(8);
         cells_y_ff <= CFG_W'(8);
         cells_z_ff <= CFG_W'(8);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CELLS_X: cells_x_ff <= csr_wdata;
            CSR_CELLS_Y: cells_y_ff <= csr_wdata;
            CSR_CELLS_Z: cells_z_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   assign nx = axis_size(cells_x_ff);
   assign ny = axis_size(cells_y_ff);
   assign nz = axis_size(cells_z_ff);

   // The front buffers one cell word, splits it into coordinates and forms
   // the wrapped column values plus the row and layer terms.
   pnc_front #(
      .AXIS_W (AXIS_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .nx             (nx),
      .ny             (ny),
      .nz             (nz),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_index (req_cell_index),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // The queue lets the front start on the next cell while the back end
   // is still walking the neighbours of the current one.
   pnc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The back end adds one column, row and layer term per neighbour and
   // takes the next cell from the queue in the cycle of the last word.
   pnc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_offset_code     (rsp_offset_code),
      .rsp_forward         (rsp_forward),
      .rsp_last            (rsp_last)
   );

endmodule

FILE: rtl/core/pnc_front.sv
// ----------------------------------------------------------------------------
// pnc_front
// Splits a linear cell index into coordinates and builds the row and layer
// terms of its neighbours with a shared radix-8 divider and one multiplier.
// ----------------------------------------------------------------------------
module pnc_front
   import pnc_pkg::*;
#(
   parameter int AXIS_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [AXIS_W-1:0]  nx,
   input  logic [AXIS_W-1:0]  ny,
   input  logic [AXIS_W-1:0]  nz,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [INDEX_W-1:0] req_cell_index,
   output logic               push_valid,
   input  logic               push_ready,
   output work_type           push_data
);

   front_state_type state_ff, state_in;

   logic               in_valid_ff;
   logic [INDEX_W-1:0] in_idx_ff;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]         axis_ff, axis_in;
   logic [INDEX_W-1:0] divd_ff;
   logic [AXIS_W-1:0]  rem_ff;
   logic [AXIS_W-1:0]  cx_ff, cy_ff, cz_ff;
   logic [INDEX_W-1:0] plane_ff;
   work_type           work_ff;

   logic               start;
   logic               div_last;
   logic [AXIS_W-1:0]  divisor;
   logic [AXIS_W:0]    trial;
   logic [AXIS_W-1:0]  div_r;
   logic [INDEX_W-1:0] div_q;

   logic [2:0][AXIS_W-1:0] wx, wy, wz;
   logic [AXIS_W-1:0]         mul_a;
   logic [INDEX_W-1:0]        mul_b;
   logic [AXIS_W+INDEX_W-1:0] prod_full;
   logic [INDEX_W-1:0]        prod;

   function automatic logic [AXIS_W-1:0] wrap_coord(
      input logic [AXIS_W-1:0] c,
      input logic [1:0]        d,
      input logic [AXIS_W-1:0] n
   );
      logic [AXIS_W:0] up;
      logic [AXIS_W-1:0] res;
      up  = {1'b0, c} + {{AXIS_W{1'b0}}, 1'b1};
      res = c;
      if (d == STEP_MINUS) begin
         res = (c == '0) ? n - AXIS_W'(1) : c - AXIS_W'(1);
      end else if (d == STEP_PLUS) begin
         res = (up >= {1'b0, n}) ? '0 : up[AXIS_W-1:0];
      end
      return res;
   endfunction

   // Divisor for the axis currently being peeled off.
   always_comb begin
      unique case (axis_ff)
         AXIS_X:  divisor = nx;
         AXIS_Y:  divisor = ny;
         default: divisor = nz;
      endcase
   end

   // Three restoring division steps per cycle; quotient bits shift into
   // the low end of the dividend register.
   always_comb begin
      div_r = rem_ff;
      div_q = divd_ff;
      trial = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {div_r, div_q[INDEX_W-1]};
         div_q = {div_q[INDEX_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial    = trial - {1'b0, divisor};
            div_q[0] = 1'b1;
         end
         div_r = trial[AXIS_W-1:0];
      end
   end

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         wx[d] = wrap_coord(cx_ff, 2'(d), nx);
         wy[d] = wrap_coord(cy_ff, 2'(d), ny);
         wz[d] = wrap_coord(cz_ff, 2'(d), nz);
      end
   end

   // Shared multiplier operands per step.
   always_comb begin
      case (step_ff)
         3'd0:    begin mul_a = ny;    mul_b = INDEX_W'(nx); end
         3'd1:    begin mul_a = wy[0]; mul_b = INDEX_W'(nx); end
         3'd2:    begin mul_a = wy[1]; mul_b = INDEX_W'(nx); end
         3'd3:    begin mul_a = wy[2]; mul_b = INDEX_W'(nx); end
         3'd4:    begin mul_a = wz[0]; mul_b = plane_ff;     end
         3'd5:    begin mul_a = wz[1]; mul_b = plane_ff;     end
         default: begin mul_a = wz[2]; mul_b = plane_ff;     end
      endcase
   end

   assign prod_full = {{INDEX_W{1'b0}}, mul_a} * {{AXIS_W{1'b0}}, mul_b};
   assign prod      = prod_full[INDEX_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (in_valid_ff) state_in = FR_DIV;
         FR_DIV:  if (div_last && axis_ff == AXIS_Z) state_in = FR_MUL;
         FR_MUL:  if (step_ff == STEP_W'(MUL_STEPS - 1)) state_in = FR_PUSH;
         FR_PUSH: if (push_ready) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   // Outputs and counters.
   always_comb begin
      div_last   = (state_ff == FR_DIV) && (step_ff == STEP_W'(DIV_STEPS - 1));
      start      = (state_ff == FR_IDLE) && in_valid_ff;
      req_ready  = !in_valid_ff || start;
      push_valid = (state_ff == FR_PUSH);
      step_in    = '0;
      axis_in    = axis_ff;
      unique case (state_ff)
         FR_IDLE: axis_in = AXIS_X;
         FR_DIV: begin
            if (div_last) begin
               axis_in = axis_ff + 2'd1;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         FR_MUL:  step_in = step_ff + STEP_W'(1);
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FR_IDLE;
         in_valid_ff <= 1'b0;
         step_ff     <= '0;
         axis_ff     <= AXIS_X;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (start) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_idx_ff <= req_cell_index;
      end
      if (start) begin
         divd_ff <= in_idx_ff;
         rem_ff  <= '0;
      end else if (state_ff == FR_DIV) begin
         divd_ff <= div_q;
         if (div_last) begin
            // The quotient stays in place as the next axis's dividend.
            rem_ff <= '0;
            unique case (axis_ff)
               AXIS_X:  cx_ff <= div_r;
               AXIS_Y:  cy_ff <= div_r;
               default: cz_ff <= div_r;
            endcase
         end else begin
            rem_ff <= div_r;
         end
      end
      if (state_ff == FR_MUL) begin
         case (step_ff)
            3'd0: begin
               plane_ff <= prod;
               for (int d = 0; d < 3; d++) begin
                  work_ff.col[d] <= INDEX_W'(wx[d]);
               end
            end
            3'd1:    work_ff.row[0]   <= prod;
            3'd2:    work_ff.row[1]   <= prod;
            3'd3:    work_ff.row[2]   <= prod;
            3'd4:    work_ff.layer[0] <= prod;
            3'd5:    work_ff.layer[1] <= prod;
            default: work_ff.layer[2] <= prod;
         endcase
      end
   end

   assign push_data = work_ff;

`ifndef SYNTHESIS
   a_start_divides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FR_IDLE && in_valid_ff) |=> (state_ff == FR_DIV && !in_valid_ff) || in_valid_ff)
      else $error("front did not start dividing a buffered cell");
`endif

endmodule

FILE: rtl/core/pnc_queue.sv
// ----------------------------------------------------------------------------
// pnc_queue
// Two-entry queue of classified cells between the front and the back end.
// ----------------------------------------------------------------------------
module pnc_queue
   import pnc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 push, pop;

   assign push_ready = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (push && !pop) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");
`endif

endmodule

FILE: rtl/core/pnc_back.sv
// ----------------------------------------------------------------------------
// pnc_back
// Walks the 27 neighbours of one classified cell and delivers one result
// word per cycle through an output register while the receiver is ready.
// ----------------------------------------------------------------------------
module pnc_back
   import pnc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  work_type           pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_neighbour_index,
   output logic [CODE_W-1:0]  rsp_offset_code,
   output logic               rsp_forward,
   output logic               rsp_last
);

   work_type           entry_ff;
   logic               busy_ff;
   logic [1:0]         ox_ff, oy_ff, oz_ff;
   logic [CODE_W-1:0]  code_ff;
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic               rsp_forward_ff;
   logic               rsp_last_ff;

   logic               load;
   logic               last_now;
   logic [INDEX_W-1:0] sum;

   assign load      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign last_now  = (code_ff == CODE_LAST);
   assign pop_ready = !busy_ff || (load && last_now);
   assign sum       = entry_ff.col[ox_ff] + entry_ff.row[oy_ff] + entry_ff.layer[oz_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ox_ff        <= STEP_MINUS;
         oy_ff        <= STEP_MINUS;
         oz_ff        <= STEP_MINUS;
         code_ff      <= '0;
      end else begin
         if (pop_valid && pop_ready) begin
            busy_ff <= 1'b1;
            ox_ff   <= STEP_MINUS;
            oy_ff   <= STEP_MINUS;
            oz_ff   <= STEP_MINUS;
            code_ff <= '0;
         end else if (load) begin
            if (last_now) busy_ff <= 1'b0;
            code_ff <= code_ff + CODE_W'(1);
            if (ox_ff == STEP_PLUS) begin
               ox_ff <= STEP_MINUS;
               if (oy_ff == STEP_PLUS) begin
                  oy_ff <= STEP_MINUS;
                  oz_ff <= oz_ff + 2'd1;
               end else begin
                  oy_ff <= oy_ff + 2'd1;
               end
            end else begin
               ox_ff <= ox_ff + 2'd1;
            end
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         entry_ff <= pop_data;
      end
      if (load) begin
         rsp_index_ff   <= sum;
         rsp_code_ff    <= code_ff;
         rsp_forward_ff <= (ox_ff != STEP_MINUS) && (oy_ff != STEP_MINUS) &&
                           (oz_ff != STEP_MINUS);
         rsp_last_ff    <= last_now;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_neighbour_index = rsp_index_ff;
   assign rsp_offset_code     = rsp_code_ff;
   assign rsp_forward         = rsp_forward_ff;
   assign rsp_last            = rsp_last_ff;

`ifndef SYNTHESIS
   a_code_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=>
         (rsp_valid && rsp_offset_code == $past(rsp_offset_code) + CODE_W'(1)))
      else $error("neighbour words out of order or with a gap");
   a_last_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_offset_code == CODE_LAST))
      else $error("last flag on a word other than the final neighbour");
   a_forward_codes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_forward) |->
         (rsp_offset_code == 5'd13 || rsp_offset_code == 5'd14 ||
          rsp_offset_code == 5'd16 || rsp_offset_code == 5'd17 ||
          rsp_offset_code == 5'd22 || rsp_offset_code == 5'd23 ||
          rsp_offset_code == 5'd25 || rsp_offset_code == 5'd26))
      else $error("forward flag on a neighbour with a negative offset");
`endif

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the periodic 27-neighbour cell generator against a predictor of its
// own. Cell words go in over a valid/ready channel in random bursts, and each
// accepted cell queues its 27 expected neighbour words. Every neighbour word
// that leaves the block is matched field by field against the oldest queued
// expectation. Axis sizes are rewritten between phases while the block is
// idle, covering zero, one, the largest legal size and oversized values.
// ----------------------------------------------------------------------------
module testbench;
   import pnc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIDE        = 64;
   // Longest stretch without any accepted word before the run is declared hung.
   // A healthy run never idles much longer than one pipeline latency plus a
   // sender gap and a receiver stall, so this leaves a wide margin.
   localparam int HANG_LIMIT      = 2000;
   // Cycles to linger after the last neighbour word, about one pipeline latency.
   localparam int TAIL_CYCLES     = 40;
   localparam int RANDOM_PHASES   = 5;
   localparam int CELLS_PER_PHASE = 24;

   // The block decodes only three register indexes; the fourth is unused.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // One expected neighbour word.
   typedef struct {
      logic [INDEX_W-1:0] neighbour;
      logic [CODE_W-1:0]  code;
      logic               forward;
      logic               last;
   } neighbour_word_type;

   // Every input of the block holds a known value from time zero.
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic [INDEX_W-1:0]     req_cell_index = '0;
   logic                   rsp_ready      = 1'b0;
   logic                   csr_valid      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CFG_W-1:0]       csr_wdata      = '0;

   logic                   req_ready;
   logic                   rsp_valid;
   logic [INDEX_W-1:0]     rsp_neighbour_index;
   logic [CODE_W-1:0]      rsp_offset_code;
   logic                   rsp_forward;
   logic                   rsp_last;
   logic                   csr_ready;

   // Our own copy of the axis size registers, as written through the port.
   logic [CFG_W-1:0] grid_x_reg = CFG_W'(8);
   logic [CFG_W-1:0] grid_y_reg = CFG_W'(8);
   logic [CFG_W-1:0] grid_z_reg = CFG_W'(8);

   neighbour_word_type expected_neighbours[$];

   int failures       = 0;
   int cells_sent     = 0;
   int words_checked  = 0;
   int grid_settings  = 0;
   int quiet_cycles   = 0;
   int rx_left        = 0;
   bit rx_open        = 1'b0;

   periodic_neighbour_cell_gen #(
      .MAX_CELLS_PER_SIDE (MAX_SIDE)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_offset_code     (rsp_offset_code),
      .rsp_forward         (rsp_forward),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // A size register of zero behaves as a single cell, and anything above the
   // largest side is clamped to it.
   function automatic int axis_cells(input logic [CFG_W-1:0] size_reg);
      if (size_reg == '0) return 1;
      if (int'(size_reg) > MAX_SIDE) return MAX_SIDE;
      return int'(size_reg);
   endfunction

   // Moves one coordinate by one step with periodic wrap on an axis of n cells.
   function automatic int wrap_coord(input int c, input logic [1:0] step, input int n);
      case (step)
         STEP_MINUS: return (c == 0) ? n - 1 : c - 1;
         STEP_PLUS:  return (c + 1 >= n) ? 0 : c + 1;
         default:    return c;
      endcase
   endfunction

   // Splits a cell index into coordinates under the current sizes and queues
   // the 27 neighbour words in order of their neighbour number. An index past
   // the end of the grid simply wraps along z.
   function automatic void predict_neighbours(input logic [INDEX_W-1:0] cell_idx);
      int nx, ny, nz, cx, cy, cz, wx, wy, wz;
      logic [1:0] sx, sy, sz;
      neighbour_word_type w;
      nx = axis_cells(grid_x_reg);
      ny = axis_cells(grid_y_reg);
      nz = axis_cells(grid_z_reg);
      cx = int'(cell_idx) % nx;
      cy = (int'(cell_idx) / nx) % ny;
      cz = (int'(cell_idx) / (nx * ny)) % nz;
      for (int i = 0; i < NUM_NEIGHBOURS; i++) begin
         sx = 2'(i % 3);
         sy = 2'((i / 3) % 3);
         sz = 2'(i / 9);
         wx = wrap_coord(cx, sx, nx);
         wy = wrap_coord(cy, sy, ny);
         wz = wrap_coord(cz, sz, nz);
         w.neighbour = INDEX_W'(wx + wy * nx + wz * nx * ny);
         w.code      = CODE_W'(i);
         w.forward   = (sx != STEP_MINUS) && (sy != STEP_MINUS) && (sz != STEP_MINUS);
         w.last      = (w.code == CODE_LAST);
         expected_neighbours.insert(expected_neighbours.size(), w);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Channel drivers. Each one is entered right after a rising edge and leaves
   // valid high on return, so that a following word can reuse it without a
   // second assignment in the same step. Callers lower valid when done.
   // -------------------------------------------------------------------------

   task automatic send_cell(input logic [INDEX_W-1:0] cell_idx);
      req_valid      <= 1'b1;
      req_cell_index <= cell_idx;
      do @(posedge clock); while (!req_ready);
      predict_neighbours(cell_idx);
      cells_sent++;
   endtask

   // The predictor's registers follow the write at the edge where it lands.
   // Writes to the unused index must leave every size untouched.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_CELLS_X: grid_x_reg = data;
         CSR_CELLS_Y: grid_y_reg = data;
         CSR_CELLS_Z: grid_z_reg = data;
         default: ;
      endcase
   endtask

   task automatic set_grid(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                           input logic [CFG_W-1:0] z);
      write_csr(CSR_CELLS_X, x);
      write_csr(CSR_CELLS_Y, y);
      write_csr(CSR_CELLS_Z, z);
      csr_valid <= 1'b0;
      grid_settings++;
   endtask

   // Stops sending and waits until every queued neighbour word has come out.
   // Every cell yields words, so an empty queue means the block is idle.
   task automatic drain_neighbours;
      req_valid <= 1'b0;
      while (expected_neighbours.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset sizes of 8 per axis: both corners, an interior cell and an index
   // beyond the grid, which wraps along z.
   task automatic test_reset_grid;
      send_cell(INDEX_W'(0));
      send_cell(INDEX_W'(511));
      send_cell(INDEX_W'(73));
      send_cell({INDEX_W{1'b1}});
      drain_neighbours();
   endtask

   // Single-cell axes keep all 27 duplicates, a full 64-cube uses every index
   // bit, and zero or oversized registers take their substitute sizes.
   task automatic test_axis_extremes;
      set_grid(CFG_W'(1), CFG_W'(1), CFG_W'(1));
      send_cell(INDEX_W'(0));
      send_cell({INDEX_W{1'b1}});
      drain_neighbours();

      set_grid(CFG_W'(MAX_SIDE), CFG_W'(MAX_SIDE), CFG_W'(MAX_SIDE));
      send_cell(INDEX_W'(0));
      send_cell({INDEX_W{1'b1}});
      send_cell(INDEX_W'(131135));
      drain_neighbours();

      set_grid(CFG_W'(0), {CFG_W{1'b1}}, CFG_W'(MAX_SIDE + 1));
      send_cell(INDEX_W'(5));
      send_cell({INDEX_W{1'b1}});
      drain_neighbours();

      set_grid(CFG_W'(2), CFG_W'(3), CFG_W'(MAX_SIDE));
      send_cell(INDEX_W'(0));
      send_cell(INDEX_W'(5));
      drain_neighbours();
   endtask

   // Writes to the undecoded register index have to be dropped.
   task automatic test_unused_register;
      write_csr(CSR_UNUSED, {CFG_W{1'b1}});
      write_csr(CSR_UNUSED, CFG_W'(0));
      csr_valid <= 1'b0;
      send_cell(INDEX_W'(7));
      send_cell(INDEX_W'(200));
      drain_neighbours();
   endtask

   function automatic logic [CFG_W-1:0] pick_axis_size;
      case ($urandom_range(0, 4))
         0:       return CFG_W'($urandom_range(0, 3));
         1:       return CFG_W'($urandom_range(MAX_SIDE + 1, (1 << CFG_W) - 1));
         2:       return CFG_W'($urandom_range(MAX_SIDE - 2, MAX_SIDE));
         default: return CFG_W'($urandom_range(1, MAX_SIDE));
      endcase
   endfunction

   // Random grids, each followed by bursts of cells with random gaps. Most
   // indexes lie inside the grid; the rest cover the full index range.
   task automatic test_random_cells;
      int burst_left;
      int grid_cells;
      logic [INDEX_W-1:0] cell_idx;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_grid(pick_axis_size(), pick_axis_size(), pick_axis_size());
         grid_cells = axis_cells(grid_x_reg) * axis_cells(grid_y_reg) *
                      axis_cells(grid_z_reg);
         burst_left = $urandom_range(1, 6);
         for (int n = 0; n < CELLS_PER_PHASE; n++) begin
            if ($urandom_range(0, 3) == 0)
               cell_idx = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
            else
               cell_idx = INDEX_W'($urandom_range(0, grid_cells - 1));
            send_cell(cell_idx);
            burst_left--;
            // A burst has ended: drop valid and sit out a random gap, so that
            // the gaps land at every point of the block's 27-word walk.
            if (burst_left == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 40)) @(posedge clock);
               burst_left = $urandom_range(1, 6);
            end
         end
         drain_neighbours();
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver: long open stretches broken by short stalls.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_open = !rx_open;
         rx_left = rx_open ? $urandom_range(1, 60) : $urandom_range(1, 6);
      end
      rx_left--;
      rsp_ready <= rx_open;
   end

   // -------------------------------------------------------------------------
   // Checker: each neighbour word against the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      neighbour_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (expected_neighbours.size() == 0) begin
            $error("unexpected neighbour word: index %0d code %0d",
                   rsp_neighbour_index, rsp_offset_code);
            failures++;
         end else begin
            want = expected_neighbours.pop_front();
            if (rsp_neighbour_index !== want.neighbour) begin
               $error("neighbour_index: expected %0d, actual %0d",
                      want.neighbour, rsp_neighbour_index);
               failures++;
            end
            if (rsp_offset_code !== want.code) begin
               $error("offset_code: expected %0d, actual %0d", want.code, rsp_offset_code);
               failures++;
            end
            if (rsp_forward !== want.forward) begin
               $error("forward: expected %0d, actual %0d", want.forward, rsp_forward);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run if no word moves on any channel for too long.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("Timed out with %0d neighbour words outstanding.",
                  expected_neighbours.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence: reset once, then each test in turn.
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_grid();
      test_axis_extremes();
      test_unused_register();
      test_random_cells();

      // Everything has drained; linger about one latency to catch strays.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_neighbours.size() != 0) begin
         $error("%0d neighbour words never arrived", expected_neighbours.size());
         failures++;
      end

      $display("Covered %0d cell words and %0d neighbour words over %0d axis size settings,",
               cells_sent, words_checked, grid_settings);
      $display("including single-cell, full 64-cube, zero and oversized axes.");
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
